// ----- rtl/rct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants of the reference count table
// Table geometry, request and status codes, entry and result layouts.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 16;

  // Entries compared per memory row.
  localparam int LANES   = 8;
  localparam int LANE_W  = 3;
  localparam int ROWS    = (TABLE_ENTRIES + LANES - 1) / LANES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ISSUE_W = ROW_W + 1;

  localparam int KEY_W   = 32;
  localparam int HDL_W   = 8;
  localparam int OUT_CNT_W = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Request codes
  localparam logic [1:0] REQ_ADD_OBJ = 2'd0;
  localparam logic [1:0] REQ_ADD_REF = 2'd1;
  localparam logic [1:0] REQ_REMOVE  = 2'd2;

  typedef enum logic [2:0] {
    STATUS_UPDATED   = 3'd0,
    STATUS_INSERTED  = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_FREED     = 3'd3,
    STATUS_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] count;
    logic [HDL_W-1:0]      handler;
  } entry_t;

  typedef entry_t [LANES-1:0] row_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [LANE_W-1:0] lane;
    entry_t            entry;
  } wr_req_t;

  typedef struct packed {
    status_e              status;
    logic [OUT_CNT_W-1:0] count;
    logic                 dvalid;
    logic [KEY_W-1:0]     handle;
    logic [HDL_W-1:0]     handler;
  } res_t;

  // Lanes of a row that map onto real table slots.
  function automatic logic [LANES-1:0] lane_mask(input logic [ROW_W-1:0] row);
    logic [LANES-1:0] m;
    m = '0;
    for (int l = 0; l < LANES; l++) begin
      m[l] = ((int'(row) * LANES + l) < TABLE_ENTRIES);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/reference_count_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: a request scans the table row by row, 1 to ROWS = 8 rows, then waits for the
//   result handover; the scan stops at the row holding the key.
// Requests: one at a time, the next is taken only once idle again; the single row read
//   port of the entry memory (8 entries per row) sets the scan length.
// Reset: asynchronous, active low; empties the table (all slot valid bits cleared)
//   at once, no clearing pass; memory contents are left as they are.
// ----------------------------------------------------------------------------
// reference_count_table_top: reference count table
// Tracks object handles with a reference count and a disposal handler each.
// ----------------------------------------------------------------------------
module reference_count_table_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request beat
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [rct_pkg::KEY_W-1:0]     object_handle_i,
  input  wire logic [rct_pkg::HDL_W-1:0]     dispose_handler_i,
  // result beat
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic [rct_pkg::OUT_CNT_W-1:0]      ref_count_o,
  output logic                               dispose_valid_o,
  output logic [rct_pkg::KEY_W-1:0]          freed_handle_o,
  output logic [rct_pkg::HDL_W-1:0]          freed_handler_o
);

  logic             idle;
  logic             req_fire;
  rct_pkg::rd_req_t rd_req;
  rct_pkg::wr_req_t wr_req;
  rct_pkg::row_t    rd_data;
  logic             res_valid;
  logic             res_ready;
  rct_pkg::res_t    res;

  logic             out_valid_q, out_valid_d;
  rct_pkg::res_t    out_q;

  // Take a request beat only while the sequencer is idle.
  assign in_stall_o = !idle;
  assign req_fire   = in_valid_i && !in_stall_o;

  // Hand a finished result over whenever the output register is empty or draining.
  assign res_ready  = !out_valid_q || !out_stall_i;

  rct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_fire_i  (req_fire),
    .req_type_i  (req_type_i),
    .req_key_i   (object_handle_i),
    .req_hdl_i   (dispose_handler_i),
    .idle_o      (idle),
    .rd_o        (rd_req),
    .wr_o        (wr_req),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  rct_store u_store (
    .clk_i     (clk_i),
    .rd_i      (rd_req),
    .wr_i      (wr_req),
    .rd_data_o (rd_data)
  );

  // Output register: hold while stalled, load on handover, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign ref_count_o     = out_q.count;
  assign dispose_valid_o = out_q.dvalid;
  assign freed_handle_o  = out_q.handle;
  assign freed_handler_o = out_q.handler;

  a_res_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> res_valid)
    else $error("finished result lost before handover");

  a_busy_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> in_stall_o)
    else $error("request taken while previous still in flight");

  a_free_disposes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.dvalid) |-> out_q.status == rct_pkg::STATUS_FREED)
    else $error("dispose flagged without freed status");

endmodule
`default_nettype wire

// ----- rtl/rct_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rct_store: entry memory
// One row of LANES entries read per cycle, registered; one entry written.
// ----------------------------------------------------------------------------
module rct_store (
  input  wire logic             clk_i,
  input  wire rct_pkg::rd_req_t rd_i,
  input  wire rct_pkg::wr_req_t wr_i,
  output rct_pkg::row_t         rd_data_o
);

  rct_pkg::row_t mem_q [rct_pkg::ROWS];
  rct_pkg::row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.row][wr_i.lane] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.row];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ----- rtl/rct_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rct_ctrl: request sequencer
// Scan memory rows for a key match and a free slot, then update at most one entry or slot valid bit.
// ----------------------------------------------------------------------------
module rct_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_fire_i,
  input  wire logic [1:0]                  req_type_i,
  input  wire logic [rct_pkg::KEY_W-1:0]   req_key_i,
  input  wire logic [rct_pkg::HDL_W-1:0]   req_hdl_i,
  output logic                             idle_o,
  output rct_pkg::rd_req_t                 rd_o,
  output rct_pkg::wr_req_t                 wr_o,
  input  wire rct_pkg::row_t               rd_data_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output rct_pkg::res_t                    res_o
);

  rct_pkg::state_e state_q, state_d;

  logic [1:0]                       req_q;
  logic [rct_pkg::KEY_W-1:0]        key_q;
  logic [rct_pkg::HDL_W-1:0]        hdl_q;
  logic [rct_pkg::ISSUE_W-1:0]      issue_q, issue_d;
  logic                             cmp_pend_q, cmp_pend_d;
  logic [rct_pkg::ROW_W-1:0]        cmp_row_q, cmp_row_d;
  logic                             hit_q, hit_d;
  logic [rct_pkg::ROW_W-1:0]        hit_row_q, hit_row_d;
  logic [rct_pkg::LANE_W-1:0]       hit_lane_q, hit_lane_d;
  rct_pkg::entry_t                  hit_ent_q, hit_ent_d;
  logic                             free_q, free_d;
  logic [rct_pkg::ROW_W-1:0]        free_row_q, free_row_d;
  logic [rct_pkg::LANE_W-1:0]       free_lane_q, free_lane_d;
  logic [rct_pkg::ROWS-1:0][rct_pkg::LANES-1:0] valid_q;

  logic [rct_pkg::LANES-1:0]        row_valid, match_vec, free_vec;
  logic                             match_any, free_any;
  logic [rct_pkg::LANE_W-1:0]       match_lane, free_lane;
  logic                             last_row, issue_more;

  logic                             fire;
  logic                             set_valid, clr_valid;
  logic [rct_pkg::COUNT_BITS-1:0]   cnt_inc, cnt_dec;

  // Row compare: lowest matching lane, lowest free lane
  always_comb begin
    row_valid  = valid_q[cmp_row_q];
    match_vec  = '0;
    free_vec   = '0;
    match_lane = '0;
    free_lane  = '0;
    for (int l = 0; l < rct_pkg::LANES; l++) begin
      match_vec[l] = row_valid[l] && (rd_data_i[l].key == key_q);
    end
    free_vec = ~row_valid & rct_pkg::lane_mask(cmp_row_q);
    for (int l = rct_pkg::LANES - 1; l >= 0; l--) begin
      if (match_vec[l]) match_lane = rct_pkg::LANE_W'(l);
      if (free_vec[l])  free_lane  = rct_pkg::LANE_W'(l);
    end
    match_any = cmp_pend_q && (|match_vec);
    free_any  = cmp_pend_q && (|free_vec);
  end

  assign issue_more = (issue_q < rct_pkg::ISSUE_W'(rct_pkg::ROWS));
  assign last_row   = cmp_pend_q && (cmp_row_q == rct_pkg::ROW_W'(rct_pkg::ROWS - 1));
  assign fire       = (state_q == rct_pkg::ST_FINISH) && res_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rct_pkg::ST_IDLE: begin
        if (req_fire_i) state_d = rct_pkg::ST_SCAN;
      end
      rct_pkg::ST_SCAN: begin
        if (match_any || last_row) state_d = rct_pkg::ST_FINISH;
      end
      rct_pkg::ST_FINISH: begin
        if (res_ready_i) state_d = rct_pkg::ST_IDLE;
      end
      default: state_d = rct_pkg::ST_IDLE;
    endcase
  end

  // Scan bookkeeping
  always_comb begin
    issue_d     = issue_q;
    cmp_pend_d  = 1'b0;
    cmp_row_d   = cmp_row_q;
    hit_d       = hit_q;
    hit_row_d   = hit_row_q;
    hit_lane_d  = hit_lane_q;
    hit_ent_d   = hit_ent_q;
    free_d      = free_q;
    free_row_d  = free_row_q;
    free_lane_d = free_lane_q;
    rd_o.en     = 1'b0;
    rd_o.row    = issue_q[rct_pkg::ROW_W-1:0];
    case (state_q)
      rct_pkg::ST_IDLE: begin
        issue_d = '0;
        hit_d   = 1'b0;
        free_d  = 1'b0;
      end
      rct_pkg::ST_SCAN: begin
        if (issue_more && !match_any) begin
          rd_o.en    = 1'b1;
          issue_d    = issue_q + rct_pkg::ISSUE_W'(1);
          cmp_pend_d = 1'b1;
          cmp_row_d  = issue_q[rct_pkg::ROW_W-1:0];
        end
        if (match_any) begin
          hit_d      = 1'b1;
          hit_row_d  = cmp_row_q;
          hit_lane_d = match_lane;
          hit_ent_d  = rd_data_i[match_lane];
        end
        if (free_any && !free_q) begin
          free_d      = 1'b1;
          free_row_d  = cmp_row_q;
          free_lane_d = free_lane;
        end
      end
      default: ;
    endcase
  end

  assign cnt_inc = (hit_ent_q.count != rct_pkg::COUNT_MAX) ?
                   hit_ent_q.count + rct_pkg::COUNT_BITS'(1) : hit_ent_q.count;
  assign cnt_dec = hit_ent_q.count - rct_pkg::COUNT_BITS'(1);

  // Result and write-back
  always_comb begin
    res_valid_o   = (state_q == rct_pkg::ST_FINISH);
    idle_o        = (state_q == rct_pkg::ST_IDLE);
    res_o.status  = rct_pkg::STATUS_NOT_FOUND;
    res_o.count   = '0;
    res_o.dvalid  = 1'b0;
    res_o.handle  = '0;
    res_o.handler = '0;
    wr_o.en       = 1'b0;
    wr_o.row      = hit_row_q;
    wr_o.lane     = hit_lane_q;
    wr_o.entry    = hit_ent_q;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    case (req_q)
      rct_pkg::REQ_ADD_OBJ: begin
        if (hit_q) begin
          wr_o.en          = fire;
          wr_o.entry.count = cnt_inc;
          res_o.status     = rct_pkg::STATUS_UPDATED;
          res_o.count      = rct_pkg::OUT_CNT_W'(cnt_inc);
        end else if (free_q) begin
          wr_o.en            = fire;
          wr_o.row           = free_row_q;
          wr_o.lane          = free_lane_q;
          wr_o.entry.key     = key_q;
          wr_o.entry.count   = rct_pkg::COUNT_BITS'(1);
          wr_o.entry.handler = hdl_q;
          set_valid          = fire;
          res_o.status       = rct_pkg::STATUS_INSERTED;
          res_o.count        = rct_pkg::OUT_CNT_W'(1);
        end else begin
          res_o.status = rct_pkg::STATUS_FULL;
        end
      end
      rct_pkg::REQ_ADD_REF: begin
        if (hit_q) begin
          wr_o.en          = fire;
          wr_o.entry.count = cnt_inc;
          res_o.status     = rct_pkg::STATUS_UPDATED;
          res_o.count      = rct_pkg::OUT_CNT_W'(cnt_inc);
        end
      end
      rct_pkg::REQ_REMOVE: begin
        if (hit_q) begin
          if (hit_ent_q.count < rct_pkg::COUNT_BITS'(2)) begin
            clr_valid     = fire;
            res_o.status  = rct_pkg::STATUS_FREED;
            res_o.dvalid  = 1'b1;
            res_o.handle  = key_q;
            res_o.handler = hit_ent_q.handler;
          end else begin
            wr_o.en          = fire;
            wr_o.entry.count = cnt_dec;
            res_o.status     = rct_pkg::STATUS_UPDATED;
            res_o.count      = rct_pkg::OUT_CNT_W'(cnt_dec);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rct_pkg::ST_IDLE;
      issue_q    <= '0;
      cmp_pend_q <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      cmp_pend_q <= cmp_pend_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      if (set_valid) valid_q[free_row_q][free_lane_q] <= 1'b1;
      if (clr_valid) valid_q[hit_row_q][hit_lane_q]   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire_i) begin
      req_q <= req_type_i;
      key_q <= req_key_i;
      hdl_q <= req_hdl_i;
    end
    cmp_row_q   <= cmp_row_d;
    hit_row_q   <= hit_row_d;
    hit_lane_q  <= hit_lane_d;
    hit_ent_q   <= hit_ent_d;
    free_row_q  <= free_row_d;
    free_lane_q <= free_lane_d;
  end

  a_rd_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_o.en |-> state_q == rct_pkg::ST_SCAN)
    else $error("row read outside scan");

  a_wr_on_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> res_valid_o && res_ready_i)
    else $error("entry write without result handover");

  a_hit_is_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rct_pkg::ST_FINISH && hit_q) |-> valid_q[hit_row_q][hit_lane_q])
    else $error("matched slot not valid");

  a_insert_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_valid |-> !valid_q[free_row_q][free_lane_q])
    else $error("insert into occupied slot");

endmodule
`default_nettype wire
